// ===== rtl/bdq_pkg.sv =====
// Package with the beat types, operation and status codes and cell control for the deque.
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;

    typedef enum logic [2:0] {
        OP_QUERY      = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_REMOVE     = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CMP  = 2'd1,
        S_UPD  = 2'd2,
        S_RES  = 2'd3
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_FROM_LEFT  = 2'd1,
        CELL_FROM_RIGHT = 2'd2,
        CELL_LOAD       = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     cmp_en;
        logic     occupied;
    } t_cell_ctl;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [4:0]         entry_count;
        logic               is_empty;
        logic               was_present;
    } t_out_beat;

endpackage

// ===== rtl/bounded_deque_with_search_top.sv =====
// A beat passes through the compare, update and read-out steps of the cell row;
// a new beat is accepted only once the previous one has left the read-out step,
// and a stalled output holds the read-out step until the held result is taken.
// The output register holds a finished result while the next beat is accepted.
// Reset (synchronous, active low) empties the deque and drops any pending result.
// Cell contents are not cleared; only occupied cells are ever read.
`timescale 1ns / 1ps

module bounded_deque_with_search_top #(
    parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bdq_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output bdq_pkg::t_out_beat o_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    bdq_pkg::t_state  r_state;
    bdq_pkg::t_state  n_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [2:0]       r_op;
    logic [bdq_pkg::DATA_W-1:0] r_val;
    bdq_pkg::t_status r_status;
    bdq_pkg::t_status w_status;
    logic             r_present;
    logic             r_out_valid;
    bdq_pkg::t_out_beat r_out;

    logic w_cmp_en;
    logic w_upd;
    logic w_res_load;
    logic w_full;
    logic w_empty;
    logic w_found;

    logic [bdq_pkg::DATA_W-1:0] w_data [CAPACITY];
    logic [CAPACITY:0]          w_seen;
    bdq_pkg::t_cell_ctl         w_ctl  [CAPACITY];
    bdq_pkg::t_cell_op          w_cop  [CAPACITY];
    logic [IW-1:0]              w_back_idx;

    // Control sequencer: next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            bdq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = bdq_pkg::S_CMP;
                end
            end
            bdq_pkg::S_CMP: n_state = bdq_pkg::S_UPD;
            bdq_pkg::S_UPD: n_state = bdq_pkg::S_RES;
            bdq_pkg::S_RES: begin
                if (!r_out_valid || i_ready) begin
                    n_state = bdq_pkg::S_IDLE;
                end
            end
            default: n_state = bdq_pkg::S_IDLE;
        endcase
    end

    // Control sequencer: outputs.
    always_comb begin
        o_ready    = 1'b0;
        w_cmp_en   = 1'b0;
        w_upd      = 1'b0;
        w_res_load = 1'b0;
        case (r_state)
            bdq_pkg::S_IDLE: o_ready    = 1'b1;
            bdq_pkg::S_CMP:  w_cmp_en   = 1'b1;
            bdq_pkg::S_UPD:  w_upd      = 1'b1;
            bdq_pkg::S_RES:  w_res_load = !r_out_valid || i_ready;
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_found = w_seen[CAPACITY];

    // Decide the status and the move of every cell for the current operation.
    always_comb begin
        w_status = bdq_pkg::ST_OK;
        n_count  = r_count;
        for (int i = 0; i < CAPACITY; i++) begin
            w_cop[i] = bdq_pkg::CELL_HOLD;
        end
        case (r_op)
            bdq_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = bdq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                    for (int i = 0; i < CAPACITY; i++) begin
                        w_cop[i] = bdq_pkg::CELL_FROM_LEFT;
                    end
                end
            end
            bdq_pkg::OP_PUSH_BACK: begin
                if (w_full) begin
                    w_status = bdq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (CW'(i) == r_count) begin
                            w_cop[i] = bdq_pkg::CELL_LOAD;
                        end
                    end
                end
            end
            bdq_pkg::OP_POP_FRONT: begin
                if (w_empty) begin
                    w_status = bdq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                    for (int i = 0; i < CAPACITY; i++) begin
                        w_cop[i] = bdq_pkg::CELL_FROM_RIGHT;
                    end
                end
            end
            bdq_pkg::OP_POP_BACK: begin
                if (w_empty) begin
                    w_status = bdq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            bdq_pkg::OP_REMOVE: begin
                if (!w_found) begin
                    w_status = bdq_pkg::ST_NOT_FOUND;
                end else begin
                    n_count = r_count - CW'(1);
                    // Every cell from the first match onward pulls in its right neighbor.
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (w_seen[i+1]) begin
                            w_cop[i] = bdq_pkg::CELL_FROM_RIGHT;
                        end
                    end
                end
            end
            default: begin
                w_status = bdq_pkg::ST_OK;
            end
        endcase
    end

    assign w_seen[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_ctl[g].op       = w_upd ? w_cop[g] : bdq_pkg::CELL_HOLD;
        assign w_ctl[g].cmp_en   = w_cmp_en;
        assign w_ctl[g].occupied = (CW'(g) < r_count);

        bdq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_val   (r_val),
            .i_left  ((g == 0) ? r_val : w_data[(g == 0) ? 0 : g - 1]),
            .i_right ((g == CAPACITY - 1) ? w_data[g] :
                      w_data[(g == CAPACITY - 1) ? g : g + 1]),
            .i_seen  (w_seen[g]),
            .o_data  (w_data[g]),
            .o_seen  (w_seen[g+1])
        );
    end

    assign w_back_idx = IW'(r_count - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_upd) begin
                r_count <= n_count;
            end
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op  <= i_data.operation;
            r_val <= i_data.value;
        end
        if (w_upd) begin
            r_status  <= w_status;
            r_present <= w_found;
        end
        if (w_res_load) begin
            r_out.status      <= r_status;
            r_out.front_value <= w_empty ? '0 : w_data[0];
            r_out.back_value  <= w_empty ? '0 : w_data[w_back_idx];
            r_out.entry_count <= 5'(r_count);
            r_out.is_empty    <= w_empty;
            r_out.was_present <= r_present;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_fail_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd && w_status != bdq_pkg::ST_OK) |=> r_count == $past(r_count))
        else $error("failed operation changed the entry count");

    a_remove_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd && r_op == bdq_pkg::OP_REMOVE && w_status == bdq_pkg::ST_OK)
        |=> r_count == $past(r_count) - CW'(1))
        else $error("successful remove did not drop one entry");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_state == bdq_pkg::S_CMP)
        else $error("accepted beat did not start a compare");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && r_state != bdq_pkg::S_RES) |=> !r_out_valid)
        else $error("result appeared without a read-out step");

endmodule

// ===== rtl/bdq_cell.sv =====
// One storage cell of the deque row: holds an entry, compares it and moves it to a neighbor.
`timescale 1ns / 1ps

module bdq_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bdq_pkg::t_cell_ctl          i_ctl,
    input  logic [bdq_pkg::DATA_W-1:0]  i_val,
    input  logic [bdq_pkg::DATA_W-1:0]  i_left,
    input  logic [bdq_pkg::DATA_W-1:0]  i_right,
    input  logic                        i_seen,
    output logic [bdq_pkg::DATA_W-1:0]  o_data,
    output logic                        o_seen
);

    logic [bdq_pkg::DATA_W-1:0] r_data;
    logic [bdq_pkg::DATA_W-1:0] n_data;
    logic                       r_hit;

    always_comb begin
        case (i_ctl.op)
            bdq_pkg::CELL_FROM_LEFT:  n_data = i_left;
            bdq_pkg::CELL_FROM_RIGHT: n_data = i_right;
            bdq_pkg::CELL_LOAD:       n_data = i_val;
            default:                  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // The hit flag is control state for the search, so it is cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.cmp_en) begin
            r_hit <= i_ctl.occupied && (r_data == i_val);
        end
    end

    assign o_data = r_data;
    // Running OR from the front: high once any cell up to this one matched.
    assign o_seen = i_seen | r_hit;

endmodule

// ===== tb/tb_bounded_deque_with_search_top.sv =====
// Self-checking testbench for the bounded deque with search: directed and random beats.
`timescale 1ns / 1ps

module tb_bounded_deque_with_search_top;

    localparam int CAP_ENTRIES = bdq_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1280;
    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 90;
    localparam int TAIL_CYCLES = 20;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    bdq_pkg::t_in_beat   in_beat = '0;
    logic       out_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    bdq_pkg::t_out_beat  o_data;

    bdq_pkg::t_in_beat   op_backlog[$];
    bdq_pkg::t_out_beat  deque_views_q[$];
    logic [31:0] dq_cells [CAP_ENTRIES];
    int         dq_count = 0;
    int         cycle_no = 0;
    int         result_no = 0;
    int         mismatches = 0;
    int         hold_left = 0;
    logic       in_fire = 1'b0;

    // Neither side idles inside this window.
    wire quiet_span = (cycle_no >= 1500) && (cycle_no < 2300);

    bounded_deque_with_search_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (o_ready),
        .i_data  (in_beat),
        .o_valid (o_valid),
        .i_ready (out_ready),
        .o_data  (o_data)
    );

    always #1 clk = ~clk;

    // Applies one operation to the local copy of the deque and returns the view after it.
    function automatic bdq_pkg::t_out_beat apply_deque_op(input bdq_pkg::t_in_beat item);
        bdq_pkg::t_out_beat view;
        logic      hit;
        int        at;
        view = '0;
        hit = 1'b0;
        at = 0;
        for (int i = 0; i < dq_count; i++) begin
            if (!hit && dq_cells[i] == item.value) begin
                hit = 1'b1;
                at = i;
            end
        end
        view.status = bdq_pkg::ST_OK;
        case (item.operation)
            bdq_pkg::OP_PUSH_FRONT: begin
                if (dq_count >= CAP_ENTRIES) begin
                    view.status = bdq_pkg::ST_FULL;
                end else begin
                    for (int i = dq_count; i > 0; i--) dq_cells[i] = dq_cells[i - 1];
                    dq_cells[0] = item.value;
                    dq_count++;
                end
            end
            bdq_pkg::OP_PUSH_BACK: begin
                if (dq_count >= CAP_ENTRIES) begin
                    view.status = bdq_pkg::ST_FULL;
                end else begin
                    dq_cells[dq_count] = item.value;
                    dq_count++;
                end
            end
            bdq_pkg::OP_POP_FRONT: begin
                if (dq_count == 0) begin
                    view.status = bdq_pkg::ST_EMPTY;
                end else begin
                    for (int i = 0; i + 1 < dq_count; i++) dq_cells[i] = dq_cells[i + 1];
                    dq_count--;
                end
            end
            bdq_pkg::OP_POP_BACK: begin
                if (dq_count == 0) view.status = bdq_pkg::ST_EMPTY;
                else dq_count--;
            end
            bdq_pkg::OP_REMOVE: begin
                if (!hit) begin
                    view.status = bdq_pkg::ST_NOT_FOUND;
                end else begin
                    for (int i = at; i + 1 < dq_count; i++) dq_cells[i] = dq_cells[i + 1];
                    dq_count--;
                end
            end
            default: begin
            end
        endcase
        view.front_value = (dq_count != 0) ? dq_cells[0] : '0;
        view.back_value  = (dq_count != 0) ? dq_cells[dq_count - 1] : '0;
        view.entry_count = 5'(dq_count);
        view.is_empty    = (dq_count == 0);
        view.was_present = hit;
        return view;
    endfunction

    function automatic bdq_pkg::t_in_beat make_item(input logic [2:0] op,
                                                    input logic [31:0] val);
        bdq_pkg::t_in_beat item;
        item.operation = op;
        item.value = val;
        return item;
    endfunction

    // Mostly a small pool so that removes and the search hit often.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 32'($urandom_range(0, 9)) - 32'd5;
        if (r < 70) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // push_pct sets how far a block leans toward filling or draining the deque.
    function automatic logic [2:0] pick_op(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 3'($urandom_range(6, 7));
        if (r < 12) return bdq_pkg::OP_QUERY;
        if (r < 22) return bdq_pkg::OP_REMOVE;
        if (r < 22 + push_pct) begin
            return $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK;
        end
        return $urandom_range(0, 1) ? bdq_pkg::OP_POP_FRONT : bdq_pkg::OP_POP_BACK;
    endfunction

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            if (mismatches < 10) begin
                $display("result %0d: %s expected %h, got %h", result_no, field, want, got);
            end
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : monitor
        bdq_pkg::t_out_beat want;
        cycle_no <= cycle_no + 1;
        in_fire <= rst_n && in_valid && o_ready;
        if (rst_n) begin
            if (o_valid && out_ready) begin
                if (deque_views_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("result %0d arrived with nothing expected: %h",
                                 result_no, o_data);
                    end
                    mismatches++;
                end else begin
                    want = deque_views_q.pop_front();
                    check_field("status", 32'(o_data.status), 32'(want.status));
                    check_field("front_value", o_data.front_value, want.front_value);
                    check_field("back_value", o_data.back_value, want.back_value);
                    check_field("entry_count", 32'(o_data.entry_count),
                                32'(want.entry_count));
                    check_field("is_empty", 32'(o_data.is_empty), 32'(want.is_empty));
                    check_field("was_present", 32'(o_data.was_present),
                                32'(want.was_present));
                end
                result_no++;
            end
            if (in_valid && o_ready) deque_views_q.push_back(apply_deque_op(in_beat));
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (op_backlog.size() != 0 && (quiet_span || $urandom_range(0, 99) >= 18)) begin
                in_beat <= op_backlog.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // The long hold-offs let the deque back up until it stalls its input.
    always @(negedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (cycle_no == 700 || cycle_no == 3500) begin
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= quiet_span || ($urandom_range(0, 99) >= 18);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial begin
        int push_pct;
        // Empty deque: the empty and not-found error paths and the unused codes.
        op_backlog.push_back(make_item(bdq_pkg::OP_QUERY, 32'd0));
        op_backlog.push_back(make_item(bdq_pkg::OP_POP_FRONT, 32'd1));
        op_backlog.push_back(make_item(bdq_pkg::OP_POP_BACK, 32'd2));
        op_backlog.push_back(make_item(bdq_pkg::OP_REMOVE, 32'd5));
        op_backlog.push_back(make_item(3'd6, 32'hFFFF_FFFF));
        op_backlog.push_back(make_item(3'd7, 32'h0000_0000));
        // Extreme values at both ends.
        op_backlog.push_back(make_item(bdq_pkg::OP_PUSH_BACK, 32'h8000_0000));
        op_backlog.push_back(make_item(bdq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF));
        op_backlog.push_back(make_item(bdq_pkg::OP_QUERY, 32'h8000_0000));
        op_backlog.push_back(make_item(bdq_pkg::OP_REMOVE, 32'd123));
        // Duplicates: a remove must take the match nearest the front.
        op_backlog.push_back(make_item(bdq_pkg::OP_PUSH_BACK, 32'd7));
        op_backlog.push_back(make_item(bdq_pkg::OP_PUSH_BACK, 32'd7));
        op_backlog.push_back(make_item(bdq_pkg::OP_PUSH_FRONT, 32'd7));
        op_backlog.push_back(make_item(bdq_pkg::OP_REMOVE, 32'd7));
        op_backlog.push_back(make_item(bdq_pkg::OP_REMOVE, 32'd7));
        op_backlog.push_back(make_item(bdq_pkg::OP_POP_BACK, 32'h7FFF_FFFF));
        op_backlog.push_back(make_item(bdq_pkg::OP_POP_FRONT, 32'h8000_0000));
        op_backlog.push_back(make_item(bdq_pkg::OP_REMOVE, 32'h8000_0000));
        op_backlog.push_back(make_item(bdq_pkg::OP_QUERY, 32'h8000_0000));
        // Random blocks that lean toward filling, draining or neither.
        push_pct = 39;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 60;
                    1: push_pct = 15;
                    default: push_pct = 39;
                endcase
            end
            op_backlog.push_back(make_item(pick_op(push_pct), pick_value()));
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (op_backlog.size() != 0 || in_valid || deque_views_q.size() != 0) begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bdq_pkg.sv
rtl/bdq_cell.sv
rtl/bounded_deque_with_search_top.sv
tb/tb_bounded_deque_with_search_top.sv
